>>> rtl/smp_pkg.sv
`timescale 1ns / 1ps

package smp_pkg;

    localparam int IDX_W       = 4;
    localparam int DIM_W       = 5;
    localparam int VAL_W       = 16;
    localparam int ACC_W       = 40;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

    // configuration register indexes
    localparam logic [1:0] CFG_A_ROWS    = 2'd0;
    localparam logic [1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [1:0] CFG_B_COLS    = 2'd2;

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_WRITE_B = 2'd1,
        ACT_ACC_A   = 2'd2,
        ACT_READ_C  = 2'd3
    } t_action;

endpackage

>>> rtl/smp_ram.sv
`timescale 1ns / 1ps

module smp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/smp_mac.sv
`timescale 1ns / 1ps

module smp_mac #(
    parameter int AW = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_issue,
    input  logic [AW-1:0]                   i_addr,
    input  logic signed [smp_pkg::VAL_W-1:0] i_mult,
    input  logic signed [smp_pkg::VAL_W-1:0] i_b_rdata,
    input  logic signed [smp_pkg::ACC_W-1:0] i_c_rdata,
    output logic                            o_busy,
    output logic                            o_we,
    output logic [AW-1:0]                   o_waddr,
    output logic [smp_pkg::ACC_W-1:0]       o_wdata
);

    localparam int PW = 2 * smp_pkg::VAL_W;
    localparam int SW = smp_pkg::ACC_W + 1;
    localparam logic [smp_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(smp_pkg::ACC_W-1){1'b1}}};
    localparam logic [smp_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(smp_pkg::ACC_W-1){1'b0}}};

    logic                            r_v1;
    logic                            r_v2;
    logic [AW-1:0]                   r_a1;
    logic [AW-1:0]                   r_a2;
    logic signed [PW-1:0]            r_prod;
    logic signed [smp_pkg::ACC_W-1:0] r_acc;
    logic signed [SW-1:0]            n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_issue;
            r_v2 <= r_v1;
        end
    end

    // memory data arrives in the cycle after issue
    always_ff @(posedge i_clk) begin
        r_a1   <= i_addr;
        r_a2   <= r_a1;
        r_prod <= PW'(i_mult) * PW'(i_b_rdata);
        r_acc  <= i_c_rdata;
    end

    assign n_sum = SW'(r_acc) + SW'(r_prod);

    always_comb begin
        if (n_sum[SW-1] != n_sum[SW-2]) begin
            o_wdata = n_sum[SW-1] ? ACC_MIN : ACC_MAX;
        end else begin
            o_wdata = n_sum[SW-2:0];
        end
    end

    assign o_we    = r_v2;
    assign o_waddr = r_a2;
    assign o_busy  = r_v1 | r_v2;

endmodule

>>> rtl/sparse_matrix_product.sv
`timescale 1ns / 1ps

// channel   direction  handshake                       payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata row, col, value; tuser action
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata out_row, out_col, out_value; tlast
// cfg       in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// a clear transaction sweeps every entry of both memories, MAX_DIM*MAX_DIM in all,
// with s_axis_tready low. the same sweep runs after reset. accumulate runs one
// multiply-accumulate per cycle, one for each column below b_cols, through the
// read-modify-write loop on the accumulator memory.
// read-row fetches one entry at a time (memory read then output register) and stalls
// while m_axis_tready is low. reset is synchronous, active low.

module sparse_matrix_product #(
    parameter int MAX_DIM = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [smp_pkg::DIM_W-1:0]         i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [smp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // row, col, value
    input  logic [1:0]                        s_axis_tuser,  // action
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [smp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // out_row, out_col, out_value
    output logic                              m_axis_tlast
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = smp_pkg::DIM_W;
    localparam int IW    = smp_pkg::IDX_W;
    localparam logic [DW-1:0] CAP = (MAX_DIM < 16) ? DW'(MAX_DIM) : DW'(16);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC,
        S_READ
    } t_state;

    function automatic logic [DW-1:0] f_eff(input logic [DW-1:0] x);
        return (x > CAP) ? CAP : x;
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return AW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    t_state                           r_state;
    logic [AW-1:0]                    r_clr;
    logic [DW-1:0]                    r_a_rows;
    logic [DW-1:0]                    r_inner_dim;
    logic [DW-1:0]                    r_b_cols;
    logic [IW-1:0]                    r_row;
    logic [IW-1:0]                    r_col;
    logic [smp_pkg::VAL_W-1:0]        r_val;
    logic [DW-1:0]                    r_nc;
    logic [DW-1:0]                    r_j;
    logic                             r_pend;
    logic                             r_out_valid;
    logic [IW-1:0]                    r_out_row;
    logic [IW-1:0]                    r_out_col;
    logic [smp_pkg::ACC_W-1:0]        r_out_value;
    logic                             r_out_last;

    logic [IW-1:0]                    in_row;
    logic [IW-1:0]                    in_col;
    logic [smp_pkg::VAL_W-1:0]        in_val;
    smp_pkg::t_action                 in_act;
    logic [DW-1:0]                    nr;
    logic [DW-1:0]                    nk;
    logic [DW-1:0]                    nc;
    logic                             accept;
    logic                             clearing;
    logic                             acc_issue;
    logic                             rd_issue;
    logic                             b_we_wr;
    logic                             b_we;
    logic [AW-1:0]                    b_waddr;
    logic [smp_pkg::VAL_W-1:0]        b_wdata;
    logic [smp_pkg::VAL_W-1:0]        b_rdata;
    logic                             c_we;
    logic [AW-1:0]                    c_waddr;
    logic [smp_pkg::ACC_W-1:0]        c_wdata;
    logic [smp_pkg::ACC_W-1:0]        c_rdata;
    logic                             mac_busy;
    logic                             mac_we;
    logic [AW-1:0]                    mac_waddr;
    logic [smp_pkg::ACC_W-1:0]        mac_wdata;

    assign in_row = s_axis_tdata[3:0];
    assign in_col = s_axis_tdata[7:4];
    assign in_val = s_axis_tdata[23:8];
    assign in_act = smp_pkg::t_action'(s_axis_tuser);

    assign nr = f_eff(r_a_rows);
    assign nk = f_eff(r_inner_dim);
    assign nc = f_eff(r_b_cols);

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE) && !mac_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign clearing      = (r_state == S_CLEAR);
    assign acc_issue     = (r_state == S_ACC);
    assign rd_issue      = (r_state == S_READ) && !r_pend && (r_j != r_nc)
                           && (!r_out_valid || m_axis_tready);

    assign b_we_wr = accept && (in_act == smp_pkg::ACT_WRITE_B)
                     && ({1'b0, in_row} < nk) && ({1'b0, in_col} < nc);

    assign b_we    = clearing || b_we_wr;
    assign b_waddr = clearing ? r_clr : f_addr(in_row, in_col);
    assign b_wdata = clearing ? '0 : in_val;

    assign c_we    = clearing || mac_we;
    assign c_waddr = clearing ? r_clr : mac_waddr;
    assign c_wdata = clearing ? '0 : mac_wdata;

    smp_ram #(
        .WIDTH (smp_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (acc_issue),
        .i_raddr (f_addr(r_col, r_j[IW-1:0])),
        .o_rdata (b_rdata)
    );

    smp_ram #(
        .WIDTH (smp_pkg::ACC_W),
        .DEPTH (DEPTH)
    ) u_c_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (acc_issue || rd_issue),
        .i_raddr (f_addr(r_row, r_j[IW-1:0])),
        .o_rdata (c_rdata)
    );

    smp_mac #(
        .AW (AW)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_issue   (acc_issue),
        .i_addr    (f_addr(r_row, r_j[IW-1:0])),
        .i_mult    (r_val),
        .i_b_rdata (b_rdata),
        .i_c_rdata (c_rdata),
        .o_busy    (mac_busy),
        .o_we      (mac_we),
        .o_waddr   (mac_waddr),
        .o_wdata   (mac_wdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_a_rows    <= smp_pkg::DIM_RESET;
            r_inner_dim <= smp_pkg::DIM_RESET;
            r_b_cols    <= smp_pkg::DIM_RESET;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == smp_pkg::CFG_A_ROWS) begin
                    r_a_rows <= i_cfg_data;
                end else if (i_cfg_index == smp_pkg::CFG_INNER_DIM) begin
                    r_inner_dim <= i_cfg_data;
                end else if (i_cfg_index == smp_pkg::CFG_B_COLS) begin
                    r_b_cols <= i_cfg_data;
                end
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_row <= in_row;
                        r_col <= in_col;
                        r_val <= in_val;
                        r_nc  <= nc;
                        r_j   <= '0;
                        unique case (in_act)
                            smp_pkg::ACT_CLEAR: begin
                                r_clr   <= '0;
                                r_state <= S_CLEAR;
                            end
                            smp_pkg::ACT_WRITE_B: begin
                                r_state <= S_IDLE;
                            end
                            smp_pkg::ACT_ACC_A: begin
                                if (({1'b0, in_row} < nr) && ({1'b0, in_col} < nk)
                                        && (nc != '0)) begin
                                    r_state <= S_ACC;
                                end
                            end
                            smp_pkg::ACT_READ_C: begin
                                if (({1'b0, in_row} < nr) && (nc != '0)) begin
                                    r_state <= S_READ;
                                end
                            end
                        endcase
                    end
                end
                S_ACC: begin
                    r_j <= r_j + 1'b1;
                    if (r_j + 1'b1 == r_nc) begin
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    if (rd_issue) begin
                        r_j <= r_j + 1'b1;
                    end
                    if (r_pend && (r_j == r_nc)) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase

            // output register is always empty when read data lands
            r_pend <= rd_issue;
            if (r_pend) begin
                r_out_valid <= 1'b1;
                r_out_row   <= r_row;
                r_out_col   <= IW'(r_j - 1'b1);
                r_out_value <= c_rdata;
                r_out_last  <= (r_j == r_nc);
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_value, r_out_col, r_out_row};
    assign m_axis_tlast  = r_out_last;

endmodule

>>> rtl/smp_checker.sv
`timescale 1ns / 1ps

module smp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic [1:0]                        i_cfg_index,
    input logic [smp_pkg::DIM_W-1:0]         i_cfg_data,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [smp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input logic [1:0]                        s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [smp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input logic                              m_axis_tlast
);

    // memories are swept right after reset
    a_sweep_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !s_axis_tready)
        else $error("input accepted during post-reset sweep");

    // a clear transaction starts a sweep
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == smp_pkg::ACT_CLEAR))
        |=> !s_axis_tready)
        else $error("input accepted straight after clear");

    // mid-row output means the row read is still running
    a_row_in_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input accepted while a row is being emitted");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output transaction changed");

endmodule

bind sparse_matrix_product smp_checker u_smp_checker (.*);
